// File: rtl/s256sh_pkg.sv
// ----------------------------------------------------------------------------
// s256sh_pkg: shared types and constants of the SHA-256 stream hasher
// Item structs, operation codes, round constants, initial hash value and
// the round functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s256sh_pkg;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } s256sh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } s256sh_out_t;

  // index 0 is H0 / a
  typedef logic [7:0][31:0] s256sh_hash_t;

  typedef struct packed {
    logic push;   // shift one message word into the schedule window
    logic start;  // begin compressing the window into the hash
    logic init;   // restore the initial hash value
  } s256sh_ctl_t;

  localparam s256sh_hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Absorbs one byte per item, compresses each full 64-byte block, pads on
// finish and returns the digest as eight 32-bit words.
// ----------------------------------------------------------------------------
//  port group   dir  handshake               payload
//  in_*         in   in_valid_i / in_stall_o  s256sh_in_t  (operation, data_byte)
//  out_*        out  out_valid_o / out_stall_i s256sh_out_t (digest_word, index, last)
//
//  The byte that fills a block also starts a compression (64 rounds on the
//  single round unit, then a fold into the hash) and the FSM waits in StWait.
//  A finish item feeds padding one byte per cycle up to the block end, then
//  compresses; with 56 or more bytes buffered this happens twice.
//  The eight digest words follow, one per cycle when out_stall_i is low.
//  in_stall_o is high from a block fill until its compression ends, and
//  from a finish until the last word leaves.
//  Reset loads the initial hash value; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher
  import s256sh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire s256sh_in_t  in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output s256sh_out_t      out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [23:0] acc_q, acc_d;
  logic        first_q, first_d;
  logic        len_ok_q, len_ok_d;
  logic        final_q, final_d;
  logic        pad_q, pad_d;
  logic [2:0]  idx_q, idx_d;

  logic         in_acc;
  logic         out_acc;
  logic         byte_go;
  logic [7:0]   byte_val;
  logic [7:0]   len_byte;
  logic         core_busy;
  s256sh_ctl_t  ctl;
  s256sh_hash_t hash;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = (state_q == StEmit);
  assign out_acc     = out_valid_o & ~out_stall_i;

  assign len_byte = 8'(bits_q >> {3'd7 - fill_q[2:0], 3'b000});

  always_comb begin
    byte_go  = 1'b0;
    byte_val = in_data_i.data_byte;
    if (in_acc && in_data_i.operation == OpAbsorb) begin
      byte_go = 1'b1;
    end else if (state_q == StPad) begin
      byte_go = 1'b1;
      if (first_q) begin
        byte_val = 8'h80;
      end else if (len_ok_q && fill_q >= 6'd56) begin
        byte_val = len_byte;
      end else begin
        byte_val = 8'h00;
      end
    end
  end

  always_comb begin
    ctl.push  = byte_go && (fill_q[1:0] == 2'b11);
    ctl.start = byte_go && (fill_q == 6'd63);
    ctl.init  = out_acc && out_data_o.last_word;
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    bits_d   = bits_q;
    acc_d    = acc_q;
    first_d  = first_q;
    len_ok_d = len_ok_q;
    final_d  = final_q;
    pad_d    = pad_q;
    idx_d    = idx_q;
    if (byte_go) begin
      acc_d  = {acc_q[15:0], byte_val};
      fill_d = fill_q + 6'd1;
      if (ctl.start) begin
        state_d = StWait;
      end
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_data_i.operation == OpAbsorb) begin
            bits_d = bits_q + 64'd8;
          end else begin
            state_d  = StPad;
            first_d  = 1'b1;
            len_ok_d = 1'b0;
            final_d  = 1'b0;
            pad_d    = 1'b1;
          end
        end
      end
      StPad: begin
        first_d = 1'b0;
        if (ctl.start) begin
          len_ok_d = 1'b1;
          final_d  = len_ok_q && !first_q;
        end else if (first_q) begin
          len_ok_d = (fill_q < 6'd56);
        end
      end
      StWait: begin
        if (!core_busy) begin
          if (final_q) begin
            state_d = StEmit;
            idx_d   = '0;
          end else if (pad_q) begin
            state_d = StPad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = StIdle;
            bits_d  = '0;
            fill_d  = '0;
            pad_d   = 1'b0;
            final_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      bits_q   <= '0;
      first_q  <= 1'b0;
      len_ok_q <= 1'b0;
      final_q  <= 1'b0;
      pad_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bits_q   <= bits_d;
      first_q  <= first_d;
      len_ok_q <= len_ok_d;
      final_q  <= final_d;
      pad_q    <= pad_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  s256sh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .word_i ({acc_q, byte_val}),
    .busy_o (core_busy),
    .hash_o (hash)
  );

  always_comb begin
    out_data_o.digest_word = hash[idx_q];
    out_data_o.word_index  = idx_q;
    out_data_o.last_word   = (idx_q == 3'd7);
  end

endmodule

`default_nettype wire

// File: rtl/s256sh_core.sv
// ----------------------------------------------------------------------------
// s256sh_core: SHA-256 compression unit
// Sixteen-word schedule window fed one word at a time, one round per
// cycle for 64 rounds, then a fold of the working words into the hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s256sh_core
  import s256sh_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire s256sh_ctl_t  ctl_i,
  input  wire logic [31:0]  word_i,
  output logic              busy_o,
  output s256sh_hash_t      hash_o
);

  logic [15:0][31:0] win_q;
  s256sh_hash_t      work_q;
  s256sh_hash_t      hash_q;
  logic [5:0]        rnd_q;
  logic              run_q;
  logic              fold_q;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    ch    = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj   = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1    = work_q[7] + big_sigma1(work_q[4]) + ch + RoundK[rnd_q] + win_q[0];
    t2    = big_sigma0(work_q[0]) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      win_q <= {word_i, win_q[15:1]};
    end else if (run_q) begin
      win_q <= {w_new, win_q[15:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      work_q <= hash_q;
    end else if (run_q) begin
      work_q <= {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
      rnd_q  <= '0;
      run_q  <= 1'b0;
      fold_q <= 1'b0;
    end else begin
      if (ctl_i.init) begin
        hash_q <= HashInit;
      end else if (fold_q) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + work_q[i];
        end
      end
      fold_q <= 1'b0;
      if (ctl_i.start) begin
        rnd_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          run_q  <= 1'b0;
          fold_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = run_q | fold_q;
  assign hash_o = hash_q;

endmodule

`default_nettype wire

// File: rtl/s256sh_checker.sv
// ----------------------------------------------------------------------------
// s256sh_checker: port-level checks of the SHA-256 stream hasher
// Digest words leave in order while input is held off; handshake sanity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s256sh_checker
  import s256sh_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire s256sh_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest item changed while stalled");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last_word disagrees with word_index");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest pending");

  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && (out_data_o.word_index == 3'($past(out_data_o.word_index) + 3'd1)))
    else $error("digest words out of sequence");

  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_data_o.word_index == 3'd0))
    else $error("digest does not start at word 0");

endmodule

bind sha256_stream_hasher s256sh_checker u_s256sh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sha256_stream_hasher
// Streams byte messages through the hasher with random gaps and output
// stalls, predicts each digest with an independent SHA-256 model and checks
// every digest word, index and last flag in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import s256sh_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 200;

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  s256sh_in_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  s256sh_out_t out_data_o;

  sha256_stream_hasher uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] chain [8];
  logic [7:0]  msg_buf [64];
  int          fill;
  logic [63:0] msg_bits;

  s256sh_in_t  pending [$];
  s256sh_out_t digest_q [$];
  int          errors = 0;
  int          items_accepted = 0;
  int          words_seen = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          cycles = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic s256sh_in_t mk_item(input logic op, input logic [7:0] b);
    s256sh_in_t it;
    it.operation = op;
    it.data_byte = b;
    return it;
  endfunction

  // bursts with no idling every few dozen items / words
  function automatic int draw_gap();
    if ((items_accepted / 40) % 4 == 3) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic int draw_stall();
    if ((words_seen / 16) % 3 == 2) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain[i] = ShaIv[i];
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_buf();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ShaK[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4];
      r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0];
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
  endtask

  task automatic hash_item(input s256sh_in_t it);
    s256sh_out_t dw;
    if (it.operation == OpAbsorb) begin
      msg_buf[fill] = it.data_byte;
      fill++;
      msg_bits = msg_bits + 64'd8;
      if (fill == 64) begin
        compress_buf();
        fill = 0;
      end
    end else begin
      msg_buf[fill] = 8'h80;
      fill++;
      // length field no longer fits: extra block
      if (fill > 56) begin
        while (fill < 64) begin
          msg_buf[fill] = 8'h00;
          fill++;
        end
        compress_buf();
        fill = 0;
      end
      while (fill < 56) begin
        msg_buf[fill] = 8'h00;
        fill++;
      end
      for (int i = 0; i < 8; i++) msg_buf[56+i] = msg_bits[63-8*i -: 8];
      compress_buf();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = chain[i];
        dw.word_index  = i[2:0];
        dw.last_word   = (i == 7);
        digest_q.push_back(dw);
      end
      clear_hash();
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    logic offered;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
      clear_hash();
    end else begin
      offered = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        hash_item(in_data_i);
        items_accepted++;
        offered = 1'b0;
      end
      if (!offered) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0) begin
          in_data_i  <= pending.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    s256sh_out_t exp_w;
    int s;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      s = stall_left;
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest word: expected none, got %h idx %0d last %b",
                   $time, out_data_o.digest_word, out_data_o.word_index,
                   out_data_o.last_word);
          errors++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data_o.digest_word !== exp_w.digest_word) begin
            $display("%0t digest_word mismatch: expected %h, got %h",
                     $time, exp_w.digest_word, out_data_o.digest_word);
            errors++;
          end
          if (out_data_o.word_index !== exp_w.word_index) begin
            $display("%0t word_index mismatch: expected %0d, got %0d",
                     $time, exp_w.word_index, out_data_o.word_index);
            errors++;
          end
          if (out_data_o.last_word !== exp_w.last_word) begin
            $display("%0t last_word mismatch: expected %b, got %b",
                     $time, exp_w.last_word, out_data_o.last_word);
            errors++;
          end
        end
        words_seen++;
        // long hold mid-digest so the input side backs up
        s = (words_seen == 11) ? HoldCycles : draw_stall();
      end
      if (s > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= s - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stim_p
    int pad_lens [9];
    int total;
    int len;
    int pick;
    pad_lens = '{0, 55, 56, 57, 63, 64, 65, 119, 120};

    // empty message, data ignored on finish
    pending.push_back(mk_item(OpFinish, 8'hff));
    // byte extremes
    pending.push_back(mk_item(OpAbsorb, 8'h00));
    pending.push_back(mk_item(OpAbsorb, 8'hff));
    pending.push_back(mk_item(OpAbsorb, 8'h61));
    pending.push_back(mk_item(OpFinish, 8'h00));

    total = 0;
    while (total < 400) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 15);
      else if (pick < 9) len = pad_lens[$urandom_range(0, 8)];
      else len = $urandom_range(0, 130);
      for (int i = 0; i < len; i++) pending.push_back(mk_item(OpAbsorb, 8'($urandom)));
      pending.push_back(mk_item(OpFinish, 8'($urandom)));
      total += len + 1;
    end

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
